### design/dsbp_pkg.sv
// Shared types and constants for the delta sample bit packer.
package dsbp_pkg;

  // Opcodes of an input item.
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Code word layout: 4 bits of length, 1 sign bit, then up to 15 value bits.
  localparam int unsigned LEN_BITS   = 4;
  localparam int unsigned HDR_BITS   = LEN_BITS + 1;
  localparam int unsigned VAL_BITS   = 15;
  localparam int unsigned CODE_BITS  = HDR_BITS + VAL_BITS;
  localparam int unsigned PEND_BITS  = 7;
  localparam int unsigned ACC_BITS   = CODE_BITS + PEND_BITS;
  localparam int unsigned MAX_BYTES  = 3;
  localparam logic [VAL_BITS-1:0] LOW15_MASK = 15'h7fff;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One input item.
  typedef struct packed {
    logic               opcode;
    logic signed [15:0] sample;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // The bytes that one input item causes, as they travel through the queue.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                nbytes;
  } entry_t;

endpackage

### design/delta_sample_bit_packer_unit.sv
// Top level of the delta sample bit packer: front, queue and back.
//
// Usage: the input channel (in_valid_i, in_ready_o, in_data_i) takes one item
// per handshake: an encode item with a 16-bit sample, or a flush item. Each
// sample is predicted as twice the last sample minus the one before it, and
// the error becomes a code word of 5 to 20 bits packed LSB first. The output
// channel (out_valid_o, out_ready_i, out_data_o) carries one completed byte
// per handshake; last_of_run marks the final byte caused by an item.
// An item gives zero to three bytes; a flush gives the zero-padded partial
// byte, if any bits are pending, and clears the predictor and the packer.
// When the queue is empty, the first byte of an item is offered in the cycle
// after it is accepted. Throughput: one item per cycle while items cause at
// most one byte each and the receiver is ready; the back sends one byte per
// cycle while out_ready_i is high; a two-entry queue absorbs the difference.
// When the receiver stalls, the queue fills and in_ready_o falls once both
// entries are taken. Reset clears the predictor, the pending bits and the
// queue; no clearing pass is needed.
module delta_sample_bit_packer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dsbp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dsbp_pkg::out_item_t out_data_o
);

  logic             push;
  dsbp_pkg::entry_t push_data;
  logic             q_full;
  logic             pop;
  logic             q_valid;
  dsbp_pkg::entry_t q_head;

  // Prediction and packing.
  dsbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Decoupling queue.
  dsbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Byte serializer.
  dsbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/dsbp_front.sv
// Front part: predicts each sample, builds its code word and packs it into bytes.
module dsbp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dsbp_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output dsbp_pkg::entry_t  push_data_o
);

  logic [15:0] last_q, last_d;
  logic [15:0] second_q, second_d;
  logic [dsbp_pkg::PEND_BITS-1:0] pend_q, pend_d;
  logic [2:0] cnt_q, cnt_d;

  logic accept;
  logic [15:0] pred;
  logic [15:0] err;
  logic        neg;
  logic [dsbp_pkg::VAL_BITS-1:0] mag;
  logic [dsbp_pkg::VAL_BITS-1:0] val_mask;
  logic [dsbp_pkg::LEN_BITS-1:0] n;
  logic [dsbp_pkg::CODE_BITS-1:0] code;
  logic [dsbp_pkg::ACC_BITS-1:0] acc;
  logic [4:0] tot;
  logic [1:0] nbytes;
  logic [dsbp_pkg::PEND_BITS-1:0] rest;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Prediction error and its magnitude bits.
  assign pred = {last_q[14:0], 1'b0} - second_q;
  assign err  = in_data_i.sample - pred;
  assign neg  = err[15];
  assign mag  = neg ? ~err[14:0] : err[14:0];

  // Priority encoder: one more than the position of the highest set bit.
  always_comb begin
    n = '0;
    for (int i = 0; i < dsbp_pkg::VAL_BITS; i++) begin
      if (mag[i]) begin
        n = dsbp_pkg::LEN_BITS'(i + 1);
      end
    end
  end

  // Code word, then merged above the pending bits.
  assign val_mask = dsbp_pkg::LOW15_MASK >> (4'd15 - n);
  assign code     = {err[14:0] & val_mask, neg, n};
  assign acc      = ({{dsbp_pkg::PEND_BITS{1'b0}}, code} << cnt_q)
                  | {{dsbp_pkg::CODE_BITS{1'b0}}, pend_q};
  assign tot      = {2'b00, cnt_q} + {1'b0, n} + 5'(dsbp_pkg::HDR_BITS);
  assign nbytes   = tot[4:3];

  // Bits left over after the complete bytes are taken off.
  always_comb begin
    case (nbytes)
      2'd0:    rest = acc[6:0];
      2'd1:    rest = acc[14:8];
      2'd2:    rest = acc[22:16];
      default: rest = {4'b0000, acc[26:24]};
    endcase
  end

  // Next state and the entry handed to the queue.
  always_comb begin
    last_d   = last_q;
    second_d = second_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    push_o   = 1'b0;
    push_data_o.bytes  = {acc[23:16], acc[15:8], acc[7:0]};
    push_data_o.nbytes = nbytes;
    if (accept) begin
      if (in_data_i.opcode == dsbp_pkg::OP_FLUSH) begin
        push_o             = (cnt_q != 3'd0);
        push_data_o.bytes  = {16'h0000, 1'b0, pend_q};
        push_data_o.nbytes = 2'd1;
        last_d   = '0;
        second_d = '0;
        pend_d   = '0;
        cnt_d    = '0;
      end else begin
        push_o   = (nbytes != 2'd0);
        second_d = last_q;
        last_d   = in_data_i.sample;
        pend_d   = rest;
        cnt_d    = tot[2:0];
      end
    end
  end

  // Predictor and packer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      second_q <= '0;
      pend_q   <= '0;
      cnt_q    <= '0;
    end else begin
      last_q   <= last_d;
      second_q <= second_d;
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef SYNTH
  // A flush leaves the predictor and the packer cleared.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.opcode == dsbp_pkg::OP_FLUSH)
    |=> (cnt_q == 3'd0) && (pend_q == '0) && (last_q == '0) && (second_q == '0))
    else $error("flush did not clear the state");
`endif

endmodule

### design/dsbp_queue.sv
// Short queue of packed byte groups between the front and the back.
module dsbp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dsbp_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output dsbp_pkg::entry_t head_o
);

  dsbp_pkg::entry_t slots_q [dsbp_pkg::QUEUE_DEPTH];
  logic [dsbp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [dsbp_pkg::QCNT_W-1:0] count_q, count_d;
  logic do_pop;

  assign full_o  = (count_q == dsbp_pkg::QCNT_W'(dsbp_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

`ifndef SYNTH
  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");
  // Occupancy never goes beyond the depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dsbp_pkg::QCNT_W'(dsbp_pkg::QUEUE_DEPTH))
    else $error("queue occupancy out of range");
`endif

endmodule

### design/dsbp_back.sv
// Back part: sends the bytes of each queued group one per cycle while out_ready_i is high.
module dsbp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  dsbp_pkg::entry_t   q_head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dsbp_pkg::out_item_t out_data_o
);

  logic [1:0] idx_q, idx_d;
  logic       is_last;
  logic       fire;

  assign is_last     = (idx_q == (q_head_i.nbytes - 2'd1));
  assign out_valid_o = q_valid_i;
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && is_last;

  // Current byte of the head group.
  always_comb begin
    out_data_o.last_of_run = is_last;
    case (idx_q)
      2'd0:    out_data_o.out_byte = q_head_i.bytes[0];
      2'd1:    out_data_o.out_byte = q_head_i.bytes[1];
      default: out_data_o.out_byte = q_head_i.bytes[2];
    endcase
  end

  // Byte index within the group.
  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTH
  // A queued group always holds at least one byte, and the index stays inside it.
  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> (q_head_i.nbytes != 2'd0) && (idx_q < q_head_i.nbytes))
    else $error("byte index outside the queued group");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for the delta sample bit packer with random stalls on both sides.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RANDOM_ITEMS = 310;
  localparam int unsigned IDLE_PCT     = 17;
  // Items sent inside this window see no idling on either side.
  localparam int unsigned CALM_FROM    = 140;
  localparam int unsigned CALM_TO      = 220;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  dsbp_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  dsbp_pkg::out_item_t out_data_o;

  delta_sample_bit_packer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Items waiting to be sent and bytes the block still owes.
  dsbp_pkg::in_item_t  todo_items[$];
  dsbp_pkg::out_item_t expected_bytes[$];
  int unsigned sent_cnt = 0;
  int unsigned err_cnt  = 0;
  logic        in_acc   = 1'b0;

  // Predictor state: the two previous samples and the unsent stream bits.
  logic [15:0] last_smp;
  logic [15:0] older_smp;
  logic [6:0]  pend_bits;
  logic [2:0]  pend_cnt;

  // Free running clock.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Random idling, switched off for a stretch of the run.
  function automatic bit take_break();
    if (sent_cnt >= CALM_FROM && sent_cnt < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // Clear the predictor and the packer, as after reset or a flush.
  task automatic clear_packer();
    last_smp  = '0;
    older_smp = '0;
    pend_bits = '0;
    pend_cnt  = '0;
  endtask

  // Work out the bytes one accepted item causes and queue them.
  task automatic predict_bytes(input dsbp_pkg::in_item_t it);
    logic [15:0] pred;
    logic [15:0] err;
    logic [14:0] mag;
    logic [15:0] vmask;
    logic [19:0] code;
    logic [26:0] acc;
    logic        neg;
    int unsigned n;
    int unsigned tot;
    int unsigned nb;
    dsbp_pkg::out_item_t ob;
    if (it.opcode == dsbp_pkg::OP_FLUSH) begin
      if (pend_cnt != 0) begin
        ob.out_byte    = {1'b0, pend_bits};
        ob.last_of_run = 1'b1;
        expected_bytes.push_back(ob);
      end
      clear_packer();
    end else begin
      // Second order prediction; everything wraps at 16 bits.
      pred = (last_smp << 1) - older_smp;
      err  = it.sample - pred;
      neg  = err[15];
      mag  = neg ? ~err[14:0] : err[14:0];
      n    = 0;
      for (int i = 0; i < 15; i++) begin
        if (mag[i]) n = i + 1;
      end
      vmask = (16'h1 << n) - 16'h1;
      code  = {err[14:0] & vmask[14:0], neg, 4'(n)};
      acc   = 27'(pend_bits) | (27'(code) << pend_cnt);
      tot   = pend_cnt + n + 5;
      nb    = tot / 8;
      for (int j = 0; j < nb; j++) begin
        ob.out_byte    = acc[8*j +: 8];
        ob.last_of_run = (j == nb - 1);
        expected_bytes.push_back(ob);
      end
      older_smp = last_smp;
      last_smp  = it.sample;
      pend_cnt  = 3'(tot - 8 * nb);
      pend_bits = 7'((acc >> (8 * nb)) & ((27'h1 << pend_cnt) - 27'h1));
    end
  endtask

  task automatic flag_error(input string what, input dsbp_pkg::out_item_t exp_b,
                            input dsbp_pkg::out_item_t got_b);
    if (err_cnt < 10) begin
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b", $realtime,
               what, exp_b.out_byte, exp_b.last_of_run, got_b.out_byte, got_b.last_of_run);
    end
    err_cnt++;
  endtask

  // Driver: inputs change at the falling edge; valid holds until the item is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= !take_break();
      if (!in_valid_i || in_acc) begin
        if (todo_items.size() > 0 && !take_break()) begin
          in_data_i  <= todo_items.pop_front();
          in_valid_i <= 1'b1;
          sent_cnt   <= sent_cnt + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: handshakes are sampled at the rising edge.
  always @(posedge clk_i) begin
    dsbp_pkg::out_item_t exp_b;
    in_acc <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_bytes(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          flag_error("unexpected byte", '0, out_data_o);
        end else begin
          exp_b = expected_bytes.pop_front();
          if (exp_b.out_byte !== out_data_o.out_byte) begin
            flag_error("out_byte mismatch", exp_b, out_data_o);
          end
          if (exp_b.last_of_run !== out_data_o.last_of_run) begin
            flag_error("last_of_run mismatch", exp_b, out_data_o);
          end
        end
      end
    end
  end

  function automatic dsbp_pkg::in_item_t make_item(input logic op, input logic [15:0] smp);
    dsbp_pkg::in_item_t it;
    it.opcode = op;
    it.sample = smp;
    return it;
  endfunction

  // Pick a sample: smooth steps, full range, extremes, scaled noise or a repeat.
  function automatic logic [15:0] pick_sample(input logic [15:0] prev);
    logic [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(0, 5)) inside
      0, 1: return prev + 16'($signed(r) >>> $urandom_range(6, 15));
      2: return r;
      3: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      4: return 16'($signed(r) >>> $urandom_range(0, 15));
      default: return prev;
    endcase
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    logic [15:0] prev;
    int unsigned len;
    clear_packer();

    // Directed items: empty flush, zero error, extremes, the 0x8000 error and wrapping.
    todo_items.push_back(make_item(dsbp_pkg::OP_FLUSH, 16'h1234));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h0000));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h0000));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h7fff));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h8000));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h7fff));
    todo_items.push_back(make_item(dsbp_pkg::OP_FLUSH, 16'hffff));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h8000));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h0001));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'hffff));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h5555));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'haaaa));
    todo_items.push_back(make_item(dsbp_pkg::OP_FLUSH, 16'h0000));
    todo_items.push_back(make_item(dsbp_pkg::OP_FLUSH, 16'h0000));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h0000));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h4000));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'hc000));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h4000));
    todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, 16'h7ffe));
    todo_items.push_back(make_item(dsbp_pkg::OP_FLUSH, 16'h8000));

    // Random runs of samples, mostly closed by a flush, with stray flushes as noise.
    prev = '0;
    while (todo_items.size() < 20 + RANDOM_ITEMS) begin
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          todo_items.push_back(make_item(dsbp_pkg::OP_FLUSH, 16'($urandom)));
          prev = '0;
        end else begin
          prev = pick_sample(prev);
          todo_items.push_back(make_item(dsbp_pkg::OP_ENCODE, prev));
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        todo_items.push_back(make_item(dsbp_pkg::OP_FLUSH, 16'($urandom)));
        prev = '0;
      end
    end
    todo_items.push_back(make_item(dsbp_pkg::OP_FLUSH, 16'h0000));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (todo_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog on the cycle count.
  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
design/dsbp_pkg.sv
design/dsbp_front.sv
design/dsbp_queue.sv
design/dsbp_back.sv
design/delta_sample_bit_packer_unit.sv
test/tb_top.sv
